// ===== rtl/core/dsrc_pkg.sv =====
// Shared types and constants for the display sleep and repolarize controller.
package dsrc_pkg;

    localparam int TIMEOUT_W = 16;
    localparam int IDLE_W    = 32;
    localparam int THRESH_W  = 26;
    localparam int PHASE_W   = 5;
    localparam int COUNT_W   = 2;
    localparam int OUT_W     = 8;

    localparam logic [9:0]         MS_PER_S          = 10'd1000;
    localparam logic [PHASE_W-1:0] REPOLARIZE_PERIOD = 5'd30;
    localparam logic [COUNT_W-1:0] WAKE_FRAMES       = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PRESS   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_FRAME   = 2'd3
    } t_op;

    typedef struct packed {
        logic wake_pending;
        logic cover_white;
        logic is_asleep;
        logic backlight_on;
    } t_result;

endpackage

// ===== rtl/core/display_sleep_repolarize_ctrl.sv =====
// Top level of the display sleep and repolarize controller.
// Each input item is one event (tick, press, release, frame) and yields exactly one result
// item with the state after that event. An item is held in the input register and is then
// written into the state update and result register, from which its result is presented.
// One item is taken every cycle while the result side is ready; the single state update
// stage sets that rate. The timeout register may only be written while no item is in
// flight; its millisecond threshold is computed on the write.
module display_sleep_repolarize_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] idle_ms
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] backlight_on, [1] is_asleep, [2] cover_white,
                                        // [3] wake_pending, [7:4] zero
);
    import dsrc_pkg::*;

    logic                st_valid;
    t_op                 st_op;
    logic [IDLE_W-1:0]   st_idle_ms;
    logic [THRESH_W-1:0] st_thresh;
    logic                advance;
    t_result             result;

    dsrc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_idle_ms  (s_axis_tdata),
        .i_advance  (advance),
        .o_valid    (st_valid),
        .o_op       (st_op),
        .o_idle_ms  (st_idle_ms),
        .o_thresh   (st_thresh)
    );

    dsrc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (st_valid),
        .o_advance(advance),
        .i_op     (st_op),
        .i_idle_ms(st_idle_ms),
        .i_thresh (st_thresh),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {(OUT_W - $bits(t_result))'(0), result};

endmodule

// ===== rtl/core/dsrc_in_stage.sv =====
// Input item register and sleep threshold register.
module dsrc_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dsrc_pkg::TIMEOUT_W-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_op,
    input  logic [dsrc_pkg::IDLE_W-1:0]    i_idle_ms,
    input  logic                          i_advance,
    output logic                          o_valid,
    output dsrc_pkg::t_op                 o_op,
    output logic [dsrc_pkg::IDLE_W-1:0]    o_idle_ms,
    output logic [dsrc_pkg::THRESH_W-1:0]  o_thresh
);
    import dsrc_pkg::*;

    logic                r_valid;
    t_op                 r_op;
    logic [IDLE_W-1:0]   r_idle_ms;
    logic [THRESH_W-1:0] r_thresh;
    logic [THRESH_W-1:0] n_thresh;

    // The millisecond threshold is formed once per configuration write;
    // a zero threshold means sleep is disabled.
    assign n_thresh = THRESH_W'(i_cfg_wdata) * THRESH_W'(MS_PER_S);
    assign o_ready  = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_thresh <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= n_thresh;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op      <= t_op'(i_op);
            r_idle_ms <= i_idle_ms;
        end
    end

    assign o_valid   = r_valid;
    assign o_op      = r_op;
    assign o_idle_ms = r_idle_ms;
    assign o_thresh  = r_thresh;

endmodule

// ===== rtl/core/dsrc_core.sv =====
// Sleep state update and result register.
module dsrc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_advance,
    input  dsrc_pkg::t_op                i_op,
    input  logic [dsrc_pkg::IDLE_W-1:0]   i_idle_ms,
    input  logic [dsrc_pkg::THRESH_W-1:0] i_thresh,
    output logic                         o_valid,
    input  logic                         i_ready,
    output dsrc_pkg::t_result            o_result
);
    import dsrc_pkg::*;

    logic               r_asleep, n_asleep;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_white, n_white;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_light, n_light;
    logic               r_out_valid;
    t_result            r_result;
    t_result            n_result;
    logic [PHASE_W:0]   phase_inc;
    logic               take;

    assign o_advance = !r_out_valid || i_ready;
    assign take      = i_valid && o_advance;
    assign phase_inc = {1'b0, r_phase} + (PHASE_W+1)'(1);

    always_comb begin
        n_asleep = r_asleep;
        n_phase  = r_phase;
        n_white  = r_white;
        n_count  = r_count;
        n_light  = r_light;
        unique case (i_op)
            OP_TICK: begin
                if (r_asleep) begin
                    if (phase_inc >= {1'b0, REPOLARIZE_PERIOD}) begin
                        n_phase = '0;
                        n_white = !r_white;
                    end else begin
                        n_phase = phase_inc[PHASE_W-1:0];
                    end
                end else if (i_thresh != '0 && i_idle_ms >= IDLE_W'(i_thresh)) begin
                    n_asleep = 1'b1;
                    n_phase  = '0;
                    n_white  = 1'b0;
                    n_count  = '0;
                    n_light  = 1'b0;
                end
            end
            OP_PRESS: begin
                if (r_asleep) begin
                    n_white = 1'b0;
                    n_count = WAKE_FRAMES;
                end
            end
            OP_RELEASE: begin
                n_asleep = 1'b0;
            end
            OP_FRAME: begin
                // The backlight comes on as the countdown reaches zero.
                if (r_count != '0) begin
                    n_count = r_count - COUNT_W'(1);
                    if (r_count == COUNT_W'(1)) begin
                        n_light = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        n_result.backlight_on = n_light;
        n_result.is_asleep    = n_asleep;
        n_result.cover_white  = n_asleep && n_white;
        n_result.wake_pending = (n_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asleep    <= 1'b0;
            r_phase     <= '0;
            r_white     <= 1'b0;
            r_count     <= '0;
            r_light     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_asleep <= n_asleep;
                r_phase  <= n_phase;
                r_white  <= n_white;
                r_count  <= n_count;
                r_light  <= n_light;
            end
            if (o_advance) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/core/dsrc_checker.sv =====
// Port-level checks for the display sleep controller, bound to the top level.
module dsrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // A white cover is only ever reported while asleep.
    a_white_needs_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[2] || m_axis_tdata[1]))
        else $error("cover_white reported while awake");

    // No result can be pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A ready result side always lets the input side move.
    a_ready_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind display_sleep_repolarize_ctrl dsrc_checker u_dsrc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
